// ===== hw/rtl/atte_pkg.sv =====
`default_nettype none
package atte_pkg;

  // screen geometry is tied to the port widths and the power-of-two ring wrap
  localparam int MaxCols = 128;
  localparam int MaxRows = 64;

  localparam logic [7:0] EscByte = 8'd27;
  localparam logic [7:0] LfByte  = 8'd10;
  localparam logic [7:0] CrByte  = 8'd13;
  localparam logic [7:0] BsByte  = 8'd8;
  localparam logic [15:0] AccumMax = 16'hFFFF;

  localparam logic [1:0] ModeNormal = 2'd0;
  localparam logic [1:0] ModeEsc    = 2'd1;
  localparam logic [1:0] ModeCsi    = 2'd2;

  localparam logic [6:0] BlankChar = 7'd32;
  localparam logic [2:0] PenFgReset = 3'd7;
  localparam logic [2:0] PenBgReset = 3'd0;

  localparam logic RegCols = 1'b0;
  localparam logic RegRows = 1'b1;

  typedef struct packed {
    logic [2:0] bg;
    logic [2:0] fg;
    logic [6:0] ch;
  } cell_t;

endpackage
`default_nettype wire

// ===== hw/rtl/atte_ram.sv =====
`default_nettype none
module atte_ram #(
  parameter int Width = 13,
  parameter int Depth = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/ansi_text_terminal_engine.sv =====
`default_nettype none
// ANSI text terminal engine.
// Input channel: in_valid_i/in_stall_o with op_i, data_byte_i, read_row_i,
// read_col_i. op 0 feeds one host byte to the escape parser and the screen;
// op 1 reads one visible cell. Every request yields one result on the output
// channel (out_valid_o/out_stall_i) carrying the cell and the cursor/parser
// state after the request.
// A printable byte, a control byte or a read: the request passes through
// StOut (StCap for a visible-cell read, capturing the screen RAM output)
// before the result is registered; no new request is taken until idle.
// Erase sequences, the blanking of a scrolled-in line and ESC c sweep the
// screen RAM one cell a cycle with a step per row; SGR walks its parameters one a cycle.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// accepted only while the engine is idle with no result pending, and holds
// the input off while offered; clamps the cursor into the new area.
// After reset the engine sweeps all MaxRows*MaxCols cells of the screen RAM
// to blanks before the first request is accepted.
// A result is held in an output register; while out_stall_i is high it
// holds and no further request is taken.
module ansi_text_terminal_engine #(
  parameter int MAX_PARAMS = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       op_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic [5:0] read_row_i,
  input  wire logic [6:0] read_col_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [6:0]      cell_char_o,
  output logic [2:0]      cell_fg_o,
  output logic [2:0]      cell_bg_o,
  output logic [5:0]      cursor_y_o,
  output logic [6:0]      cursor_x_o,
  output logic [1:0]      parser_mode_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);
  localparam int CW = $clog2(atte_pkg::MaxCols);
  localparam int RW = $clog2(atte_pkg::MaxRows);
  localparam int AW = CW + RW;
  localparam int PW = $clog2(MAX_PARAMS);
  localparam int NW = $clog2(MAX_PARAMS + 1);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRead  = 3'd1;
  localparam logic [2:0] StCap   = 3'd2;
  localparam logic [2:0] StSweep = 3'd3;
  localparam logic [2:0] StSgr   = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;
  localparam logic [2:0] StInit  = 3'd6;

  logic [2:0] st_q, st_d;
  logic [8:0] cols_q, cols_d;   // saturated 1..MaxCols
  logic [7:0] rows_q, rows_d;
  logic [RW-1:0] top_q, top_d;
  logic [RW-1:0] cy_q, cy_d;
  logic [CW-1:0] cx_q, cx_d;
  logic [2:0] fg_q, fg_d, bg_q, bg_d;
  logic [1:0] mode_q, mode_d;
  logic [15:0] plist_q [MAX_PARAMS];
  logic [15:0] plist_d [MAX_PARAMS];
  logic [NW-1:0] pcnt_q, pcnt_d;
  logic [15:0] acc_q, acc_d;
  logic seen_q, seen_d, other_q, other_d;
  // sweep: rows sr..er-1 relative, columns rc..ec-1 on first row, 0..ec-1 on others
  logic [RW:0] sr_q, sr_d, er_q, er_d;
  logic [CW:0] ec_q, ec_d, rc_q, rc_d;
  logic [AW:0] ic_q, ic_d;
  logic [NW-1:0] si_q, si_d;
  logic [6:0] och_q, och_d;
  logic [2:0] ofg_q, ofg_d, obg_q, obg_d;
  logic ovld_q, ovld_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  atte_pkg::cell_t wdata, rdata;

  atte_ram #(.Width(13), .Depth(atte_pkg::MaxRows * atte_pkg::MaxCols)) u_ram (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] top,
                                            input logic [RW:0] r,
                                            input logic [CW:0] c);
    logic [RW-1:0] phys;
    phys = top + r[RW-1:0];
    return {phys, c[CW-1:0]};
  endfunction

  // a result leaving this cycle frees the output register for the next one
  assign in_stall_o  = (st_q != StIdle) || (ovld_q && out_stall_i) || cfg_valid_i;
  assign cfg_ready_o = (st_q == StIdle) && !ovld_q;
  assign out_valid_o = ovld_q;
  assign cell_char_o = och_q;
  assign cell_fg_o = ofg_q;
  assign cell_bg_o = obg_q;
  assign cursor_y_o = 6'(cy_q);
  assign cursor_x_o = 7'(cx_q);
  assign parser_mode_o = mode_q;

  logic acc_in;
  assign acc_in = in_valid_i && !in_stall_o;

  logic [15:0] p0, pn;
  logic [16:0] cmove;
  logic [19:0] acc_mul;
  logic [7:0] b;
  logic [15:0] pend;
  logic [NW-1:0] pcnt_f;
  logic [15:0] pv, hr, ht;
  logic [CW:0] cxp1;

  always_comb begin
    st_d = st_q; cols_d = cols_q; rows_d = rows_q; top_d = top_q;
    cy_d = cy_q; cx_d = cx_q; fg_d = fg_q; bg_d = bg_q; mode_d = mode_q;
    plist_d = plist_q; pcnt_d = pcnt_q; acc_d = acc_q; seen_d = seen_q;
    other_d = other_q; sr_d = sr_q; er_d = er_q; ec_d = ec_q;
    rc_d = rc_q; ic_d = ic_q; si_d = si_q; och_d = och_q; ofg_d = ofg_q;
    obg_d = obg_q; ovld_d = ovld_q;
    we = 1'b0; waddr = '0; raddr = '0;
    wdata = '{bg: bg_q, fg: fg_q, ch: atte_pkg::BlankChar};
    b = data_byte_i;
    p0 = '0; pn = '0; cmove = '0; acc_mul = '0; pend = '0; pcnt_f = pcnt_q;
    pv = '0; hr = '0; ht = '0; cxp1 = {1'b0, cx_q} + 1'b1;

    if (ovld_q && !out_stall_i) ovld_d = 1'b0;

    unique case (st_q)
      StInit: begin
        we = 1'b1;
        waddr = ic_q[AW-1:0];
        wdata = '{bg: atte_pkg::PenBgReset, fg: atte_pkg::PenFgReset,
                  ch: atte_pkg::BlankChar};
        ic_d = ic_q + 1'b1;
        if (ic_q[AW-1:0] == AW'(atte_pkg::MaxRows * atte_pkg::MaxCols - 1)) st_d = StIdle;
      end
      StIdle: begin
        if (cfg_valid_i && cfg_ready_o) begin
          if (cfg_index_i == atte_pkg::RegCols) begin
            cols_d = (cfg_data_i == 8'd0) ? 9'd1 :
                     ({1'b0, cfg_data_i} > 9'(atte_pkg::MaxCols)) ? 9'(atte_pkg::MaxCols)
                                                                   : {1'b0, cfg_data_i};
          end else begin
            rows_d = (cfg_data_i[6:0] == 7'd0) ? 8'd1 :
                     ({1'b0, cfg_data_i[6:0]} > 8'(atte_pkg::MaxRows)) ? 8'(atte_pkg::MaxRows)
                                                          : {1'b0, cfg_data_i[6:0]};
          end
          if ({2'b0, cy_q} >= rows_d) cy_d = RW'(rows_d - 8'd1);
          if ({2'b0, cx_q} >= cols_d) cx_d = CW'(cols_d - 9'd1);
        end
        if (acc_in) begin
          och_d = '0; ofg_d = '0; obg_d = '0;
          if (op_i) begin
            raddr = addr_of(top_q, (RW+1)'(read_row_i), (CW+1)'(read_col_i));
            if ({2'b0, read_row_i} < 8'(rows_q) && {2'b0, read_col_i} < cols_q)
              st_d = StCap;
            else
              st_d = StOut;
          end else if (mode_q == atte_pkg::ModeNormal) begin
            st_d = StOut;
            if (b == atte_pkg::EscByte) mode_d = atte_pkg::ModeEsc;
            else if (b == atte_pkg::LfByte) begin
              cx_d = '0;
              if ({2'b0, cy_q} + 8'd1 >= rows_q) begin
                top_d = top_q + 1'b1;
                cy_d = RW'(rows_q - 8'd1);
                sr_d = (RW+1)'(rows_q - 8'd1); er_d = (RW+1)'(rows_q);
                ec_d = (CW+1)'(cols_q); rc_d = '0;
                st_d = StSweep;
              end else cy_d = cy_q + 1'b1;
            end else if (b == atte_pkg::CrByte) cx_d = '0;
            else if (b == atte_pkg::BsByte) begin
              if (cx_q != '0) begin
                cx_d = cx_q - 1'b1;
                we = 1'b1;
                waddr = addr_of(top_q, {1'b0, cy_q}, {1'b0, cx_q - 1'b1});
              end
            end else if (b >= 8'd32 && b <= 8'd126) begin
              we = 1'b1;
              waddr = addr_of(top_q, {1'b0, cy_q}, {1'b0, cx_q});
              wdata = '{bg: bg_q, fg: fg_q, ch: b[6:0]};
              if ({1'b0, cxp1} >= cols_q) begin
                cx_d = '0;
                if ({2'b0, cy_q} + 8'd1 >= rows_q) begin
                  top_d = top_q + 1'b1;
                  cy_d = RW'(rows_q - 8'd1);
                  sr_d = (RW+1)'(rows_q - 8'd1); er_d = (RW+1)'(rows_q);
                  ec_d = (CW+1)'(cols_q); rc_d = '0;
                  st_d = StSweep;
                end else cy_d = cy_q + 1'b1;
              end else cx_d = cxp1[CW-1:0];
            end
          end else if (mode_q == atte_pkg::ModeEsc) begin
            mode_d = atte_pkg::ModeNormal;
            st_d = StOut;
            if (b == "[") begin
              mode_d = atte_pkg::ModeCsi;
              pcnt_d = '0; acc_d = '0; seen_d = 1'b0; other_d = 1'b0;
            end else if (b == "c") begin
              fg_d = atte_pkg::PenFgReset; bg_d = atte_pkg::PenBgReset;
              cy_d = '0; cx_d = '0; top_d = '0;
              sr_d = '0; er_d = (RW+1)'(rows_q);
              ec_d = (CW+1)'(cols_q); rc_d = '0;
              st_d = StSweep;
            end
          end else begin
            st_d = StOut;
            if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) begin
              mode_d = atte_pkg::ModeNormal;
              pend = seen_q ? acc_q : 16'd0;
              if (other_q || seen_q) begin
                if (pcnt_q < NW'(MAX_PARAMS)) begin
                  plist_d[pcnt_q[PW-1:0]] = pend;
                  pcnt_f = pcnt_q + 1'b1;
                end
              end
              pcnt_d = pcnt_f;
              p0 = (pcnt_f != '0) ? plist_d[0] : 16'd0;
              pn = (pcnt_f != '0) ? p0 : 16'd1;
              unique case (b)
                "m": begin si_d = '0; st_d = StSgr; end
                "H": begin
                  hr = (pcnt_f != '0) ? p0 : 16'd1;
                  ht = (pcnt_f > NW'(1)) ? plist_d[1] : 16'd1;
                  hr = (hr != '0) ? hr - 1'b1 : 16'd0;
                  ht = (ht != '0) ? ht - 1'b1 : 16'd0;
                  cy_d = (hr < 16'(rows_q)) ? RW'(hr) : RW'(rows_q - 8'd1);
                  cx_d = (ht < 16'(cols_q)) ? CW'(ht) : CW'(cols_q - 9'd1);
                end
                "A": cy_d = (pn >= 16'(cy_q)) ? '0 : cy_q - RW'(pn);
                "B": begin
                  cmove = 17'(cy_q) + 17'(pn);
                  cy_d = (cmove < 17'(rows_q)) ? RW'(cmove) : RW'(rows_q - 8'd1);
                end
                "C": begin
                  cmove = 17'(cx_q) + 17'(pn);
                  cx_d = (cmove < 17'(cols_q)) ? CW'(cmove) : CW'(cols_q - 9'd1);
                end
                "D": cx_d = (pn >= 16'(cx_q)) ? '0 : cx_q - CW'(pn);
                "J": begin
                  if (p0 == 16'd0) begin
                    sr_d = {1'b0, cy_q}; er_d = (RW+1)'(rows_q);
                    ec_d = (CW+1)'(cols_q);
                    rc_d = {1'b0, cx_q}; st_d = StSweep;
                  end else if (p0 == 16'd2) begin
                    sr_d = '0; er_d = (RW+1)'(rows_q);
                    ec_d = (CW+1)'(cols_q); rc_d = '0; st_d = StSweep;
                  end
                end
                "K": begin
                  sr_d = {1'b0, cy_q}; er_d = {1'b0, cy_q} + 1'b1;
                  if (p0 == 16'd0) begin
                    ec_d = (CW+1)'(cols_q);
                    rc_d = {1'b0, cx_q}; st_d = StSweep;
                  end else if (p0 == 16'd1) begin
                    ec_d = cxp1; rc_d = '0; st_d = StSweep;
                  end else if (p0 == 16'd2) begin
                    ec_d = (CW+1)'(cols_q); rc_d = '0; st_d = StSweep;
                  end
                end
                default: ;
              endcase
            end else if (b >= "0" && b <= "9") begin
              acc_mul = 20'(acc_q) * 20'd10 + 20'(b - "0");
              acc_d = (acc_mul > 20'(atte_pkg::AccumMax)) ? atte_pkg::AccumMax
                                                           : acc_mul[15:0];
              seen_d = 1'b1; other_d = 1'b0;
            end else if (b == ";") begin
              if (pcnt_q < NW'(MAX_PARAMS)) begin
                plist_d[pcnt_q[PW-1:0]] = seen_q ? acc_q : 16'd0;
                pcnt_d = pcnt_q + 1'b1;
              end
              acc_d = '0; seen_d = 1'b0; other_d = 1'b0;
            end else other_d = 1'b1;
          end
        end
      end
      StCap: begin
        och_d = rdata.ch; ofg_d = rdata.fg; obg_d = rdata.bg;
        ovld_d = 1'b1; st_d = StIdle;
      end
      StRead: st_d = StOut;
      StSweep: begin
        if (sr_q >= er_q) st_d = StOut;
        else if (rc_q >= ec_q) begin
          sr_d = sr_q + 1'b1; rc_d = '0; ec_d = (CW+1)'(cols_q);
          if (sr_q + 1'b1 >= er_q) st_d = StOut;
        end else begin
          we = 1'b1;
          waddr = addr_of(top_q, sr_q, rc_q);
          rc_d = rc_q + 1'b1;
        end
      end
      StSgr: begin
        if (si_q >= pcnt_q) st_d = StOut;
        else begin
          pv = plist_q[si_q[PW-1:0]];
          if (pv == 16'd0) begin
            fg_d = atte_pkg::PenFgReset; bg_d = atte_pkg::PenBgReset;
          end
          else if (pv >= 16'd30 && pv <= 16'd37) fg_d = 3'(pv - 16'd30);
          else if (pv >= 16'd40 && pv <= 16'd47) bg_d = 3'(pv - 16'd40);
          else if (pv >= 16'd90 && pv <= 16'd97) fg_d = 3'(pv - 16'd90);
          else if (pv >= 16'd100 && pv <= 16'd107) bg_d = 3'(pv - 16'd100);
          si_d = si_q + 1'b1;
        end
      end
      StOut: begin ovld_d = 1'b1; st_d = StIdle; end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    plist_q <= plist_d;
    sr_q <= sr_d; er_q <= er_d; ec_q <= ec_d; rc_q <= rc_d;
    si_q <= si_d; och_q <= och_d; ofg_q <= ofg_d; obg_q <= obg_d;
    acc_q <= acc_d; seen_q <= seen_d; other_q <= other_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StInit; cols_q <= 9'd80; rows_q <= 8'd24; top_q <= '0;
      cy_q <= '0; cx_q <= '0; fg_q <= atte_pkg::PenFgReset; bg_q <= atte_pkg::PenBgReset;
      mode_q <= atte_pkg::ModeNormal; pcnt_q <= '0; ic_q <= '0; ovld_q <= 1'b0;
    end else begin
      st_q <= st_d; cols_q <= cols_d; rows_q <= rows_d; top_q <= top_d;
      cy_q <= cy_d; cx_q <= cx_d; fg_q <= fg_d; bg_q <= bg_d;
      mode_q <= mode_d; pcnt_q <= pcnt_d; ic_q <= ic_d; ovld_q <= ovld_d;
    end
  end
endmodule
`default_nettype wire

// ===== tb/ansi_text_terminal_engine_tb.sv =====
`timescale 1ns / 1ps
module ansi_text_terminal_engine_tb;

  localparam int NCOLS = 128;
  localparam int NROWS = 64;
  localparam int NPARAMS = 8;
  localparam bit OpByte = 1'b0;
  localparam bit OpRead = 1'b1;
  localparam longint CycleLimit = 4000000;
  localparam int EndSettle = 400;

  typedef struct packed {
    logic [6:0] ch;
    logic [2:0] fg;
    logic [2:0] bg;
    logic [5:0] y;
    logic [6:0] x;
    logic [1:0] mode;
  } view_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic op_d = 1'b0;
  logic [7:0] byte_d = '0;
  logic [5:0] row_d = '0;
  logic [6:0] col_d = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_index = 1'b0;
  logic [7:0] cfg_data = '0;

  logic in_stall_o, out_valid_o, cfg_ready_o;
  logic [6:0] cell_char_o, cursor_x_o;
  logic [2:0] cell_fg_o, cell_bg_o;
  logic [5:0] cursor_y_o;
  logic [1:0] parser_mode_o;

  ansi_text_terminal_engine i_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o,
    .op_i(op_d), .data_byte_i(byte_d), .read_row_i(row_d), .read_col_i(col_d),
    .out_valid_o, .out_stall_i(out_stall),
    .cell_char_o, .cell_fg_o, .cell_bg_o, .cursor_y_o, .cursor_x_o, .parser_mode_o,
    .cfg_valid_i(cfg_valid), .cfg_ready_o, .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow terminal state
  atte_pkg::cell_t scr [NROWS*NCOLS];
  int unsigned cols_reg, rows_reg, top_row, cur_y, cur_x, pen_fg, pen_bg, pmode;
  int unsigned params [NPARAMS];
  int unsigned nparams, acc, have_digits, saw_other;

  view_t expected_views [$];
  int errors = 0;
  int n_bytes = 0, n_reads = 0, n_cfg = 0;
  longint cycles = 0;
  int hold_left = 0;
  int stall_span = 0, stall_rate = 0;
  bit pacing = 1'b1;
  int burst_left = 0;

  function automatic int unsigned eff_cols();
    if (cols_reg < 1) return 1;
    if (cols_reg > NCOLS) return NCOLS;
    return cols_reg;
  endfunction

  function automatic int unsigned eff_rows();
    if (rows_reg < 1) return 1;
    if (rows_reg > NROWS) return NROWS;
    return rows_reg;
  endfunction

  function automatic int unsigned cell_addr(int unsigned r, int unsigned c);
    return ((top_row + r) % NROWS) * NCOLS + (c % NCOLS);
  endfunction

  function automatic void blank_span(int unsigned r, int unsigned c0, int unsigned c1);
    for (int unsigned c = c0; c < c1; c++) begin
      scr[cell_addr(r, c)] = '{bg: pen_bg[2:0], fg: pen_fg[2:0], ch: atte_pkg::BlankChar};
    end
  endfunction

  function automatic void new_line();
    cur_x = 0;
    cur_y++;
    if (cur_y >= eff_rows()) begin
      top_row = (top_row + 1) % NROWS;
      cur_y = eff_rows() - 1;
      blank_span(cur_y, 0, eff_cols());
    end
  endfunction

  function automatic void push_param(int unsigned v);
    if (nparams < NPARAMS) begin
      params[nparams] = v;
      nparams++;
    end
  endfunction

  function automatic void clear_screen();
    for (int unsigned r = 0; r < eff_rows(); r++) blank_span(r, 0, eff_cols());
  endfunction

  function automatic void run_sequence(logic [7:0] fin);
    int unsigned rows, cols, p0, n, r, t, p;
    rows = eff_rows();
    cols = eff_cols();
    p0 = nparams > 0 ? params[0] : 0;
    n = nparams > 0 ? p0 : 1;
    case (fin)
      "m": begin
        for (int unsigned i = 0; i < nparams; i++) begin
          p = params[i];
          if (p == 0) begin
            pen_fg = atte_pkg::PenFgReset;
            pen_bg = atte_pkg::PenBgReset;
          end else if (p >= 30 && p <= 37) pen_fg = p - 30;
          else if (p >= 40 && p <= 47) pen_bg = p - 40;
          else if (p >= 90 && p <= 97) pen_fg = p - 90;
          else if (p >= 100 && p <= 107) pen_bg = p - 100;
        end
      end
      "H": begin
        r = nparams > 0 ? p0 : 1;
        t = nparams > 1 ? params[1] : 1;
        r = r > 0 ? r - 1 : 0;
        t = t > 0 ? t - 1 : 0;
        cur_y = r < rows ? r : rows - 1;
        cur_x = t < cols ? t : cols - 1;
      end
      "A": cur_y = n >= cur_y ? 0 : cur_y - n;
      "B": begin
        t = cur_y + n;
        cur_y = t < rows ? t : rows - 1;
      end
      "C": begin
        t = cur_x + n;
        cur_x = t < cols ? t : cols - 1;
      end
      "D": cur_x = n >= cur_x ? 0 : cur_x - n;
      "J": begin
        if (p0 == 0) begin
          blank_span(cur_y, cur_x, cols);
          for (r = cur_y + 1; r < rows; r++) blank_span(r, 0, cols);
        end else if (p0 == 2) begin
          clear_screen();
        end
      end
      "K": begin
        if (p0 == 0) blank_span(cur_y, cur_x, cols);
        else if (p0 == 1) blank_span(cur_y, 0, cur_x + 1);
        else if (p0 == 2) blank_span(cur_y, 0, cols);
      end
      default: ;
    endcase
  endfunction

  function automatic void take_byte(logic [7:0] b);
    int unsigned v;
    if (pmode == atte_pkg::ModeNormal) begin
      if (b == atte_pkg::EscByte) pmode = atte_pkg::ModeEsc;
      else if (b == atte_pkg::LfByte) new_line();
      else if (b == atte_pkg::CrByte) cur_x = 0;
      else if (b == atte_pkg::BsByte) begin
        if (cur_x > 0) begin
          cur_x--;
          blank_span(cur_y, cur_x, cur_x + 1);
        end
      end else if (b >= 32 && b <= 126) begin
        scr[cell_addr(cur_y, cur_x)] = '{bg: pen_bg[2:0], fg: pen_fg[2:0], ch: b[6:0]};
        cur_x++;
        if (cur_x >= eff_cols()) new_line();
      end
    end else if (pmode == atte_pkg::ModeEsc) begin
      pmode = atte_pkg::ModeNormal;
      if (b == "[") begin
        pmode = atte_pkg::ModeCsi;
        nparams = 0;
        acc = 0;
        have_digits = 0;
        saw_other = 0;
      end else if (b == "c") begin
        pen_fg = atte_pkg::PenFgReset;
        pen_bg = atte_pkg::PenBgReset;
        cur_y = 0;
        cur_x = 0;
        top_row = 0;
        clear_screen();
      end
    end else begin
      if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) begin
        if (saw_other) push_param(have_digits ? acc : 0);
        else if (have_digits) push_param(acc);
        run_sequence(b);
        pmode = atte_pkg::ModeNormal;
      end else if (b >= "0" && b <= "9") begin
        v = acc * 10 + (b - "0");
        acc = v > atte_pkg::AccumMax ? atte_pkg::AccumMax : v;
        have_digits = 1;
        saw_other = 0;
      end else if (b == ";") begin
        push_param(have_digits ? acc : 0);
        acc = 0;
        have_digits = 0;
        saw_other = 0;
      end else begin
        saw_other = 1;
      end
    end
  endfunction

  function automatic view_t predict_request(logic op, logic [7:0] b, logic [5:0] r,
                                            logic [6:0] c);
    view_t v;
    atte_pkg::cell_t cl;
    v = '0;
    if (op == OpByte) begin
      take_byte(b);
    end else if (r < eff_rows() && c < eff_cols()) begin
      cl = scr[cell_addr(r, c)];
      v.ch = cl.ch;
      v.fg = cl.fg;
      v.bg = cl.bg;
    end
    v.y = cur_y[5:0];
    v.x = cur_x[6:0];
    v.mode = pmode[1:0];
    return v;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    view_t e;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_views.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual char %0d y %0d x %0d",
                 $time, cell_char_o, cursor_y_o, cursor_x_o);
        errors++;
      end else begin
        e = expected_views.pop_front();
        if (cell_char_o !== e.ch) begin
          $display("%0t: cell_char expected %0d actual %0d", $time, e.ch, cell_char_o);
          errors++;
        end
        if (cell_fg_o !== e.fg) begin
          $display("%0t: cell_fg expected %0d actual %0d", $time, e.fg, cell_fg_o);
          errors++;
        end
        if (cell_bg_o !== e.bg) begin
          $display("%0t: cell_bg expected %0d actual %0d", $time, e.bg, cell_bg_o);
          errors++;
        end
        if (cursor_y_o !== e.y) begin
          $display("%0t: cursor_y expected %0d actual %0d", $time, e.y, cursor_y_o);
          errors++;
        end
        if (cursor_x_o !== e.x) begin
          $display("%0t: cursor_x expected %0d actual %0d", $time, e.x, cursor_x_o);
          errors++;
        end
        if (parser_mode_o !== e.mode) begin
          $display("%0t: parser_mode expected %0d actual %0d", $time, e.mode, parser_mode_o);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off set by the backpressure test
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (stall_span == 0) begin
        stall_span <= $urandom_range(16, 200);
        stall_rate <= $urandom_range(0, 3);
      end else begin
        stall_span <= stall_span - 1;
      end
      out_stall <= $urandom_range(0, 3) < stall_rate;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout", $time);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_request(logic op, logic [7:0] b, logic [5:0] r, logic [6:0] c);
    int gap;
    in_valid <= 1'b1;
    op_d <= op;
    byte_d <= b;
    row_d <= r;
    col_d <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_views = {expected_views, predict_request(op, b, r, c)};
    if (op == OpByte) n_bytes++;
    else n_reads++;
    if (pacing) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_byte(logic [7:0] b);
    send_request(OpByte, b, 6'($urandom), 7'($urandom));
  endtask

  task automatic send_read(int r, int c);
    send_request(OpRead, 8'($urandom), r[5:0], c[6:0]);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_views.size() != 0) @(posedge clk_i);
  endtask

  // both registers are written back to back, valid held across the pair
  task automatic set_geometry(logic [7:0] cols, logic [7:0] rows);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= atte_pkg::RegCols;
    cfg_data <= cols;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cols_reg = cols;
    if (cur_x >= eff_cols()) cur_x = eff_cols() - 1;
    cfg_index <= atte_pkg::RegRows;
    cfg_data <= rows;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    rows_reg = rows & 8'h7F;
    if (cur_y >= eff_rows()) cur_y = eff_rows() - 1;
    cfg_valid <= 1'b0;
    n_cfg += 2;
  endtask

  task automatic send_number(int unsigned v);
    send_text($sformatf("%0d", v));
  endtask

  function automatic int unsigned pick_param();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return $urandom_range(30, 37);
      2: return $urandom_range(40, 47);
      3: return $urandom_range(90, 97);
      4: return $urandom_range(100, 107);
      5: return $urandom_range(0, 3);
      6: return $urandom_range(0, 200);
      default: return $urandom_range(60000, 99999);
    endcase
  endfunction

  task automatic random_traffic(int count, bit allow_reset_seq);
    int k, len, start;
    logic [7:0] fin;
    logic [7:0] odd_bytes [5];
    odd_bytes = '{"?", " ", ">", "!", "$"};
    start = n_bytes + n_reads;
    while (n_bytes + n_reads - start < count) begin
      k = $urandom_range(0, 99);
      if (k < 28) begin
        if ($urandom_range(0, 9) == 0) send_read($urandom_range(0, 63), $urandom_range(0, 127));
        else send_read($urandom_range(0, eff_rows()), $urandom_range(0, eff_cols()));
      end else if (k < 52) begin
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) send_byte(8'($urandom_range(32, 126)));
      end else if (k < 62) begin
        case ($urandom_range(0, 2))
          0: send_byte(atte_pkg::LfByte);
          1: send_byte(atte_pkg::CrByte);
          default: send_byte(atte_pkg::BsByte);
        endcase
      end else if (k < 88) begin
        send_byte(atte_pkg::EscByte);
        send_byte("[");
        len = $urandom_range(0, 10);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 5))
            0, 1, 2: send_number(pick_param());
            3: send_byte(odd_bytes[$urandom_range(0, 4)]);
            default: ;
          endcase
          if (i != len - 1 || $urandom_range(0, 3) == 0) send_byte(";");
        end
        if ($urandom_range(0, 5) == 0) send_byte(odd_bytes[$urandom_range(0, 4)]);
        case ($urandom_range(0, 9))
          0: fin = "m";
          1: fin = "H";
          2: fin = "A";
          3: fin = "B";
          4: fin = "C";
          5: fin = "D";
          6: fin = "J";
          7: fin = "K";
          8: fin = "m";
          default: fin = $urandom_range(0, 1) ? 8'($urandom_range(65, 90))
                                              : 8'($urandom_range(97, 122));
        endcase
        send_byte(fin);
      end else if (k < 92) begin
        send_byte(atte_pkg::EscByte);
        if (allow_reset_seq && $urandom_range(0, 3) == 0) send_byte("c");
        else send_byte(8'($urandom));
      end else begin
        send_byte(8'($urandom));
      end
    end
  endtask

  task automatic test_text_and_controls();
    send_text("A~ ");
    send_byte(8'd127);
    send_byte(8'd255);
    send_byte(8'd0);
    send_byte(atte_pkg::BsByte);
    send_read(0, 0);
    send_read(0, 1);
    send_read(0, 2);
    send_byte(atte_pkg::CrByte);
    send_byte(atte_pkg::BsByte);
    send_byte(atte_pkg::LfByte);
    send_read(63, 127);
  endtask

  task automatic test_escape_sequences();
    send_byte(atte_pkg::EscByte); send_text("[31;42mQ");
    send_byte(atte_pkg::EscByte); send_text("[99;107mR");
    send_read(1, 0);
    send_byte(atte_pkg::EscByte); send_text("[mS");
    send_byte(atte_pkg::EscByte); send_text("[5;10H");
    send_byte(atte_pkg::EscByte); send_text("[0A");
    send_byte(atte_pkg::EscByte); send_text("[99B");
    send_byte(atte_pkg::EscByte); send_text("[C");
    send_byte(atte_pkg::EscByte); send_text("[200D");
    send_byte(atte_pkg::EscByte); send_text("[1K");
    send_byte(atte_pkg::EscByte); send_text("[0J");
    send_byte(atte_pkg::EscByte); send_text("[2J");
    send_byte(atte_pkg::EscByte); send_text("[3J");
    send_byte(atte_pkg::EscByte); send_text("[9K");
    send_byte(atte_pkg::EscByte); send_text("[1;2;3;4;5;6;7;8;9;10H");
    send_byte(atte_pkg::EscByte); send_text("[99999999;0H");
    send_byte(atte_pkg::EscByte); send_text("[?5h");
    send_byte(atte_pkg::EscByte); send_text("[3 ;H");
    send_byte(atte_pkg::EscByte); send_text("[;7?X");
    send_byte(atte_pkg::EscByte); send_text("x");
    send_byte(atte_pkg::EscByte); send_text("[44mZ");
    send_byte(atte_pkg::EscByte); send_text("c");
    send_read(0, 0);
  endtask

  task automatic test_geometry_extremes();
    set_geometry(8'd0, 8'd0);
    send_text("ab");
    send_read(0, 0);
    send_read(0, 1);
    set_geometry(8'd255, 8'd255);
    send_byte(atte_pkg::EscByte); send_text("[64;128H");
    send_text("z");
    send_read(63, 0);
    set_geometry(8'd1, 8'd200);
    send_text("q\n");
    set_geometry(8'd128, 8'd64);
    send_byte(atte_pkg::EscByte); send_text("[1;128H");
    send_text("XY");
    send_read(0, 127);
    send_read(1, 0);
  endtask

  task automatic test_random_small_screens();
    for (int ph = 0; ph < 8; ph++) begin
      set_geometry(8'($urandom_range(1, 24)), 8'($urandom_range(1, 8)));
      random_traffic(120, 1'b1);
      if (ph == 3) wait_drained();
    end
  endtask

  task automatic test_backpressure();
    in_valid <= 1'b0;
    @(negedge clk_i);
    hold_left = 500;
    @(posedge clk_i);
    pacing = 1'b0;
    random_traffic(40, 1'b0);
    pacing = 1'b1;
    wait_drained();
  endtask

  task automatic test_random_full_screen();
    set_geometry(8'd128, 8'd64);
    random_traffic(150, 1'b0);
    set_geometry(8'd80, 8'd24);
    random_traffic(200, 1'b1);
  endtask

  initial begin
    for (int i = 0; i < NROWS*NCOLS; i++) begin
      scr[i] = '{bg: atte_pkg::PenBgReset, fg: atte_pkg::PenFgReset, ch: atte_pkg::BlankChar};
    end
    cols_reg = 80; rows_reg = 24; top_row = 0; cur_y = 0; cur_x = 0;
    pen_fg = atte_pkg::PenFgReset; pen_bg = atte_pkg::PenBgReset;
    pmode = atte_pkg::ModeNormal;
    nparams = 0; acc = 0; have_digits = 0; saw_other = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_text_and_controls();
    test_escape_sequences();
    test_geometry_extremes();
    test_random_small_screens();
    test_backpressure();
    test_random_full_screen();
    wait_drained();
    repeat (EndSettle) @(posedge clk_i);
    $display("Covered %0d host bytes and %0d cell reads over %0d register writes,",
             n_bytes, n_reads, n_cfg);
    $display("including 1x1 and full-size screens and a long output hold-off.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
